[design/irft_pkg.sv]
// Shared types and constants for the IR remote frame transmitter.
// Depends on nothing; every other design file imports it.
package irft_pkg;

    // Payload bit limit, the reset values of the configuration registers, the frame timer ceiling and mark lengths.
    localparam int unsigned MAX_BITS            = 32;
    localparam logic [31:0] DATA_WORD_RESET     = 32'h0000_540A;
    localparam logic [5:0]  BIT_COUNT_RESET     = 6'd15;
    localparam logic [3:0]  START_TICKS_RESET   = 4'd4;
    localparam logic [7:0]  FRAME_TICKS_RESET   = 8'd75;
    localparam logic [7:0]  TICK_COUNT_MAX      = 8'd255;
    localparam logic [3:0]  MARK_TICKS_ONE      = 4'd2;
    localparam logic [3:0]  MARK_TICKS_ZERO     = 4'd1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WORD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 2'd3;

    // Input commands.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Keyer phases.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SPACE = 3'd2,
        PH_MARK  = 3'd3,
        PH_GAP   = 3'd4
    } t_phase;

    // Keyer state registers.
    typedef struct packed {
        t_phase     phase;
        logic [3:0] phase_ticks_left;
        logic [5:0] bits_remaining;
        logic [7:0] ticks_since_frame_start;
        logic [7:0] frames_left;
    } t_keyer_state;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] data_word;
        logic [5:0]  bit_count;
        logic [3:0]  start_ticks;
        logic [7:0]  frame_ticks;
    } t_cfg;

    // Input word.
    typedef struct packed {
        logic       command;
        logic [7:0] start_count;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic       carrier_on;
        logic [7:0] frames_pending;
        logic       busy_res;
    } t_out_word;

endpackage

[design/irft_step.sv]
// Next-state logic of the keyer: one input word advances the state by one step.
// Depends on irft_pkg for the state, configuration and word types.
module irft_step (
    input  irft_pkg::t_keyer_state i_state,
    input  irft_pkg::t_cfg         i_cfg,
    input  irft_pkg::t_in_word     i_word,
    output irft_pkg::t_keyer_state o_state,
    output irft_pkg::t_out_word    o_result
);
    import irft_pkg::*;

    logic [7:0]   tick_cnt;
    logic [5:0]   clamped_bits;
    logic [5:0]   bits_dec;
    logic [7:0]   frames_dec;
    t_keyer_state frame_start;
    t_keyer_state nxt;

    // Saturating frame timer and the values a new frame starts from.
    always_comb begin
        tick_cnt = (i_state.ticks_since_frame_start != TICK_COUNT_MAX) ?
                   i_state.ticks_since_frame_start + 8'd1 :
                   i_state.ticks_since_frame_start;
        clamped_bits = (i_cfg.bit_count > 6'(MAX_BITS)) ? 6'(MAX_BITS) : i_cfg.bit_count;
        bits_dec     = i_state.bits_remaining - 6'd1;
        frames_dec   = (i_state.frames_left != 8'd0) ? i_state.frames_left - 8'd1 : 8'd0;

        frame_start                         = i_state;
        frame_start.phase                   = PH_START;
        frame_start.phase_ticks_left        = i_cfg.start_ticks;
        frame_start.bits_remaining          = clamped_bits;
        frame_start.ticks_since_frame_start = 8'd0;
    end

    // Phase sequencing on a tick; a load only replaces the frame count.
    always_comb begin
        nxt = i_state;
        if (i_word.command == CMD_LOAD) begin
            nxt.frames_left = i_word.start_count;
        end else begin
            case (i_state.phase)
                PH_IDLE: begin
                    if (i_state.frames_left != 8'd0) begin
                        nxt = frame_start;
                    end
                end
                PH_START: begin
                    nxt.ticks_since_frame_start = tick_cnt;
                    if (i_state.phase_ticks_left <= 4'd1) begin
                        nxt.phase_ticks_left = 4'd0;
                        nxt.phase            = PH_SPACE;
                    end else begin
                        nxt.phase_ticks_left = i_state.phase_ticks_left - 4'd1;
                    end
                end
                PH_SPACE: begin
                    nxt.ticks_since_frame_start = tick_cnt;
                    if (i_state.bits_remaining == 6'd0) begin
                        nxt.phase = PH_GAP;
                    end else begin
                        nxt.bits_remaining   = bits_dec;
                        nxt.phase            = PH_MARK;
                        nxt.phase_ticks_left = i_cfg.data_word[bits_dec[4:0]] ?
                                               MARK_TICKS_ONE : MARK_TICKS_ZERO;
                    end
                end
                PH_MARK: begin
                    nxt.ticks_since_frame_start = tick_cnt;
                    if (i_state.phase_ticks_left > 4'd1) begin
                        nxt.phase_ticks_left = i_state.phase_ticks_left - 4'd1;
                    end else begin
                        nxt.phase_ticks_left = 4'd0;
                        nxt.phase = (i_state.bits_remaining != 6'd0) ? PH_SPACE : PH_GAP;
                    end
                end
                PH_GAP: begin
                    nxt.ticks_since_frame_start = tick_cnt;
                    if (tick_cnt >= i_cfg.frame_ticks) begin
                        if (frames_dec != 8'd0) begin
                            nxt             = frame_start;
                            nxt.frames_left = frames_dec;
                        end else begin
                            nxt.phase       = PH_IDLE;
                            nxt.frames_left = 8'd0;
                        end
                    end
                end
                default: begin
                    nxt.phase       = PH_IDLE;
                    nxt.frames_left = 8'd0;
                end
            endcase
        end
    end

    // The result reflects the state after the update.
    always_comb begin
        o_state                 = nxt;
        o_result.carrier_on     = (nxt.phase == PH_START) || (nxt.phase == PH_MARK);
        o_result.frames_pending = nxt.frames_left;
        o_result.busy_res       = (nxt.phase != PH_IDLE);
    end

endmodule

[design/ir_remote_frame_transmitter_unit.sv]
// IR remote frame transmitter: configuration, keyer state and result registers.
// Depends on irft_pkg and instantiates irft_step.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_data) carries one word per
//   command: a timing tick or a load of the frame count. Every accepted word
//   yields exactly one result word on the output channel (o_out_valid /
//   i_out_ready / o_out_data): carrier enable, frames pending and busy flag,
//   all taken after the update.
//   The result is registered: a word accepted at one edge has its result valid after
//   that edge. Throughput is one word per cycle while the receiver keeps up, set by the single registered
//   pass through the next-state logic.
//   The result register doubles as the output buffer. A new word is accepted
//   while the held result is taken in the same cycle; when the receiver stalls,
//   o_in_ready drops and the keyer state holds until the result leaves.
//   The configuration port writes one register per cycle at i_cfg_we; it is
//   meant to be used while the block is idle.
//   Synchronous reset (i_rst_n low) returns the keyer to idle with no frames
//   pending, clears the result valid flag and restores the register defaults.
module ir_remote_frame_transmitter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [irft_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irft_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  irft_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output irft_pkg::t_out_word                 o_out_data
);
    import irft_pkg::*;

    t_cfg         r_cfg;
    t_keyer_state r_state;
    t_keyer_state n_state;
    t_out_word    r_out;
    t_out_word    n_out;
    logic         r_out_valid;
    logic         in_fire;

    // Accept while the result register is empty or being emptied.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_word   <= DATA_WORD_RESET;
            r_cfg.bit_count   <= BIT_COUNT_RESET;
            r_cfg.start_ticks <= START_TICKS_RESET;
            r_cfg.frame_ticks <= FRAME_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DATA_WORD:   r_cfg.data_word   <= i_cfg_data;
                CFG_BIT_COUNT:   r_cfg.bit_count   <= i_cfg_data[5:0];
                CFG_START_TICKS: r_cfg.start_ticks <= i_cfg_data[3:0];
                CFG_FRAME_TICKS: r_cfg.frame_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One step of the keyer per accepted word.
    irft_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_word   (i_in_data),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Keyer state and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase                   <= PH_IDLE;
            r_state.phase_ticks_left        <= 4'd0;
            r_state.bits_remaining          <= 6'd0;
            r_state.ticks_since_frame_start <= 8'd0;
            r_state.frames_left             <= 8'd0;
            r_out_valid                     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

endmodule

[dv/tb_ir_remote_frame_transmitter_unit.sv]
`timescale 1ns / 1ps
// Testbench for ir_remote_frame_transmitter_unit: ticks and frame-count loads checked
// word by word against an in-bench keyer model under random handshake stalls.
// Depends on irft_pkg and the design top level.

module tb_ir_remote_frame_transmitter_unit;
    import irft_pkg::*;

    localparam int              CLK_HALF         = 6;
    localparam int              RESET_CYCLES     = 5;
    localparam int              TARGET_WORDS     = 550;
    localparam int              LONG_HOLD_CYCLES = 40;
    localparam int              SETTLE_CYCLES    = 4;
    localparam longint unsigned CYCLE_LIMIT      = 200000;

    // An expected result word, stamped with the time its input word was taken.
    typedef struct {
        t_out_word       word;
        longint unsigned noted_at;
    } t_awaited;

    // Keyer model plus the queue of result words it has predicted.
    class keyer_scoreboard;
        t_cfg         cfg;
        t_keyer_state ks;
        t_awaited     awaited_words[$];
        int unsigned  failures;

        function new();
            cfg.data_word   = DATA_WORD_RESET;
            cfg.bit_count   = BIT_COUNT_RESET;
            cfg.start_ticks = START_TICKS_RESET;
            cfg.frame_ticks = FRAME_TICKS_RESET;
            ks       = '0;
            ks.phase = PH_IDLE;
            failures = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DATA_WORD:   cfg.data_word   = val;
                CFG_BIT_COUNT:   cfg.bit_count   = val[5:0];
                CFG_START_TICKS: cfg.start_ticks = val[3:0];
                CFG_FRAME_TICKS: cfg.frame_ticks = val[7:0];
                default: ;
            endcase
        endfunction

        // True when the keyer is idle with nothing left to send.
        function bit is_quiet();
            return (ks.phase == PH_IDLE) && (ks.frames_left == 0);
        endfunction

        function int outstanding();
            return awaited_words.size();
        endfunction

        function void count_frame_tick();
            if (ks.ticks_since_frame_start < TICK_COUNT_MAX)
                ks.ticks_since_frame_start++;
        endfunction

        // Start mark of a new frame; payload lengths above the limit are clipped.
        function void open_frame();
            ks.phase                   = PH_START;
            ks.phase_ticks_left        = cfg.start_ticks;
            ks.bits_remaining          = (cfg.bit_count > MAX_BITS) ? 6'(MAX_BITS)
                                                                   : cfg.bit_count;
            ks.ticks_since_frame_start = '0;
        endfunction

        // One step of the keyer; returns the result word seen after the update.
        function t_out_word advance_keyer(t_in_word w);
            t_out_word r;
            if (w.command == CMD_LOAD) begin
                ks.frames_left = w.start_count;
            end else begin
                case (ks.phase)
                    PH_IDLE: begin
                        if (ks.frames_left != 0)
                            open_frame();
                    end
                    PH_START: begin
                        count_frame_tick();
                        if (ks.phase_ticks_left <= 1) begin
                            ks.phase_ticks_left = '0;
                            ks.phase            = PH_SPACE;
                        end else begin
                            ks.phase_ticks_left--;
                        end
                    end
                    PH_SPACE: begin
                        count_frame_tick();
                        if (ks.bits_remaining == 0) begin
                            ks.phase = PH_GAP;
                        end else begin
                            ks.bits_remaining--;
                            ks.phase = PH_MARK;
                            ks.phase_ticks_left = cfg.data_word[ks.bits_remaining[4:0]]
                                                  ? MARK_TICKS_ONE : MARK_TICKS_ZERO;
                        end
                    end
                    PH_MARK: begin
                        count_frame_tick();
                        if (ks.phase_ticks_left > 1) begin
                            ks.phase_ticks_left--;
                        end else begin
                            ks.phase_ticks_left = '0;
                            ks.phase = (ks.bits_remaining > 0) ? PH_SPACE : PH_GAP;
                        end
                    end
                    PH_GAP: begin
                        count_frame_tick();
                        if (ks.ticks_since_frame_start >= cfg.frame_ticks) begin
                            if (ks.frames_left > 0)
                                ks.frames_left--;
                            if (ks.frames_left > 0) begin
                                open_frame();
                            end else begin
                                ks.phase       = PH_IDLE;
                                ks.frames_left = '0;
                            end
                        end
                    end
                    default: begin
                        ks.phase       = PH_IDLE;
                        ks.frames_left = '0;
                    end
                endcase
            end
            r.carrier_on     = (ks.phase == PH_START) || (ks.phase == PH_MARK);
            r.frames_pending = ks.frames_left;
            r.busy_res       = (ks.phase != PH_IDLE);
            return r;
        endfunction

        // Called for each input word the block takes.
        function void note_word(t_in_word w);
            t_awaited a;
            a.word     = advance_keyer(w);
            a.noted_at = $time;
            awaited_words.push_back(a);
        endfunction

        // Called for each result word the block hands over.
        function void check_word(t_out_word got);
            t_awaited a;
            // An entry noted at this very edge cannot have produced a result yet.
            if (awaited_words.size() == 0 || awaited_words[0].noted_at == $time) begin
                $error("result word with no expectation waiting: carrier_on %0d, %s %0d, %s %0d",
                       got.carrier_on, "frames_pending", got.frames_pending,
                       "busy_res", got.busy_res);
                failures++;
                return;
            end
            a = awaited_words.pop_front();
            if (got.carrier_on !== a.word.carrier_on) begin
                $error("carrier_on: expected %0d, actual %0d", a.word.carrier_on,
                       got.carrier_on);
                failures++;
            end
            if (got.frames_pending !== a.word.frames_pending) begin
                $error("frames_pending: expected %0d, actual %0d", a.word.frames_pending,
                       got.frames_pending);
                failures++;
            end
            if (got.busy_res !== a.word.busy_res) begin
                $error("busy_res: expected %0d, actual %0d", a.word.busy_res, got.busy_res);
                failures++;
            end
        endfunction

        function void report_leftovers();
            if (awaited_words.size() != 0) begin
                $error("%0d result words never arrived", awaited_words.size());
                failures++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  o_in_ready;
    t_in_word              in_word;
    logic                  o_out_valid;
    logic                  out_ready;
    t_out_word             o_out_data;

    keyer_scoreboard sb = new();
    int unsigned     words_sent    = 0;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    bit              hold_output   = 1'b0;
    longint unsigned cycle_count   = 0;

    ir_remote_frame_transmitter_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // Clock.
    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: compare every word the block hands over.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready)
            sb.check_word(o_out_data);
    end

    // Receiver: random stalls, and one long hold-off when asked for.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_output) begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one word and return at the edge where the block takes it.
    task automatic send_word(input logic cmd, input logic [7:0] count);
        t_in_word w;
        w.command     = cmd;
        w.start_count = count;
        // Receiver-heavy idling first, then sender-heavy, then none.
        if (words_sent < TARGET_WORDS / 3) begin
            send_idle_pct = 38;
            recv_idle_pct = 66;
        end else if (words_sent < 2 * TARGET_WORDS / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 38;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!o_in_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(CMD_TICK, 8'($urandom));
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sb.write_register(idx, val);
        @(posedge clk);
    endtask

    // Write all four registers; only called with the keyer quiet and nothing in flight.
    task automatic write_settings(input logic [31:0] word, input logic [5:0] nbits,
                                  input logic [3:0] st, input logic [7:0] ft);
        put_register(CFG_DATA_WORD, word);
        put_register(CFG_BIT_COUNT, 32'(nbits));
        put_register(CFG_START_TICKS, 32'(st));
        put_register(CFG_FRAME_TICKS, 32'(ft));
        cfg_we <= 1'b0;
    endtask

    // Cancel further frames, tick until the keyer is quiet, then let every result drain.
    task automatic drain_keyer();
        send_word(CMD_LOAD, 8'd0);
        while (!sb.is_quiet())
            send_tick();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Mostly ticks with occasional loads, mostly of small frame counts.
    task automatic random_phase(input int n, input bit long_hold);
        logic [7:0] cnt;
        send_word(CMD_LOAD, 8'($urandom_range(1, 4)));
        if (long_hold)
            hold_output = 1'b1;
        repeat (n) begin
            if ($urandom_range(0, 24) == 0) begin
                cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                send_word(CMD_LOAD, cnt);
            end else begin
                send_tick();
            end
        end
        drain_keyer();
    endtask

    // Stimulus.
    initial begin
        int          phase_no;
        logic [5:0]  nbits;
        logic [7:0]  ft;

        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_DATA_WORD;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle tick, zero load, full load, reload while busy, zero mid-frame.
        send_word(CMD_TICK, 8'hA5);
        send_word(CMD_LOAD, 8'd0);
        send_word(CMD_TICK, 8'h5A);
        send_word(CMD_LOAD, 8'hFF);
        repeat (6) send_tick();
        send_word(CMD_LOAD, 8'd3);
        repeat (3) send_tick();
        drain_keyer();

        // Zero start mark, no payload bits and zero frame length.
        write_settings(32'h0, 6'd0, 4'd0, 8'd0);
        send_word(CMD_LOAD, 8'd2);
        repeat (6) send_tick();
        drain_keyer();

        // Longest start mark and frame, payload count above the limit.
        write_settings(32'hFFFF_FFFF, 6'h3F, 4'hF, 8'hFF);
        send_word(CMD_LOAD, 8'd1);
        repeat (3) send_tick();
        drain_keyer();

        // Random phases, each under its own settings.
        phase_no = 0;
        while (words_sent < TARGET_WORDS) begin
            case (phase_no)
                0: write_settings($urandom, 6'd32, 4'd1, 8'd1);
                1: write_settings($urandom, 6'd1, 4'($urandom_range(0, 15)),
                                  8'($urandom_range(0, 20)));
                default: begin
                    nbits = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63))
                                                        : 6'($urandom_range(0, 12));
                    ft    = ($urandom_range(0, 15) == 0) ? 8'd255
                                                         : 8'($urandom_range(0, 40));
                    write_settings($urandom, nbits, 4'($urandom_range(0, 15)), ft);
                end
            endcase
            random_phase($urandom_range(40, 80), phase_no == 0);
            phase_no++;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.report_leftovers();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
